@@ hw/rtl/aroon_window_extreme_age_macros.svh @@
// assertion macros for the aroon window extreme age block
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef AROON_WINDOW_EXTREME_AGE_MACROS_SVH
`define AROON_WINDOW_EXTREME_AGE_MACROS_SVH

// property checked at every rising clock edge outside reset
`define AWEA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked in the same cycle
`define AWEA_ASSERT_IMP(lbl, ante, cons, msg) \
    `AWEA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ hw/rtl/awea_pkg.sv @@
// shared constants and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps

package awea_pkg;

    localparam int MAX_PERIOD   = 255;
    localparam int SAMPLE_WIDTH = 32;
    localparam int FULL_SCALE   = 25600;

    localparam int CFG_PERIOD_W = 8;
    localparam int OUT_W        = 15;
    localparam int DEPTH        = MAX_PERIOD + 1;
    localparam int PERIOD_W     = $clog2(MAX_PERIOD + 1);
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int COUNT_W      = $clog2(MAX_PERIOD + 2);
    localparam int NUM_W        = PERIOD_W + $clog2(FULL_SCALE + 1);
    localparam int DIV_CNT_W    = $clog2(NUM_W + 1);

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_IDX_W    = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD = '0;
    localparam logic [CFG_PERIOD_W-1:0] PERIOD_RESET = 8'd14;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_issue;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic scan_need;
        logic scan_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/awea_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module awea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/awea_ctrl.sv @@
// controller state machine: sequences store, rescan, scoring and output
// depends on awea_pkg
`timescale 1ns / 1ps

module awea_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  awea_pkg::t_status i_status,
    output awea_pkg::t_cmd   o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_SCORE = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (!i_status.emit) begin
                    n_state = ST_IDLE;
                end else if (i_status.scan_need) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end else begin
                    n_state = ST_SCORE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_done) begin
                    n_state = ST_SCORE;
                end
            end
            ST_SCORE: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

@@ hw/rtl/awea_dp.sv @@
// datapath: window stores, extreme tracking, rescan walk, divider, output register
// depends on awea_pkg, awea_ram and the assertion macro header
`timescale 1ns / 1ps
`include "aroon_window_extreme_age_macros.svh"

module awea_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [awea_pkg::PERIOD_W-1:0]          i_period,
    input  logic                                   i_clear,
    input  logic signed [awea_pkg::SAMPLE_WIDTH-1:0] i_high_price,
    input  logic signed [awea_pkg::SAMPLE_WIDTH-1:0] i_low_price,
    input  awea_pkg::t_cmd                         i_cmd,
    output awea_pkg::t_status                      o_status,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic [awea_pkg::OUT_W-1:0]             o_aroon_up,
    output logic [awea_pkg::OUT_W-1:0]             o_aroon_down
);

    localparam int SW   = awea_pkg::SAMPLE_WIDTH;
    localparam int PW   = awea_pkg::PERIOD_W;
    localparam int SLW  = awea_pkg::SLOT_W;
    localparam int CW   = awea_pkg::COUNT_W;
    localparam int NW   = awea_pkg::NUM_W;
    localparam int DCW  = awea_pkg::DIV_CNT_W;
    localparam int OW   = awea_pkg::OUT_W;

    function automatic logic [SLW-1:0] age_of(
        input logic [SLW-1:0] newest,
        input logic [SLW-1:0] slot,
        input logic [CW-1:0]  win
    );
        logic [CW:0] raw;
        raw = {2'b00, newest} + {1'b0, win} - {2'b00, slot};
        if (raw >= {1'b0, win}) begin
            raw = raw - {1'b0, win};
        end
        return raw[SLW-1:0];
    endfunction

    function automatic logic [PW+NW-1:0] div_iter(
        input logic [PW-1:0] rem,
        input logic [NW-1:0] q,
        input logic [PW-1:0] d
    );
        logic [PW:0]   trial;
        logic [PW:0]   diff;
        logic          ge;
        logic [PW-1:0] rem_n;
        trial = {rem, q[NW-1]};
        diff  = trial - {1'b0, d};
        ge    = (trial >= {1'b0, d});
        rem_n = ge ? diff[PW-1:0] : trial[PW-1:0];
        return {rem_n, q[NW-2:0], ge};
    endfunction

    // window state
    logic [SLW-1:0]       r_newest_slot;
    logic [CW-1:0]        r_seen_count;
    logic [SLW-1:0]       r_highest_slot;
    logic signed [SW-1:0] r_highest_value;
    logic [SLW-1:0]       r_lowest_slot;
    logic signed [SW-1:0] r_lowest_value;
    logic                 r_extremes_valid;
    logic                 r_emit;
    logic                 r_rescan_hi;
    logic                 r_rescan_lo;

    // rescan walk
    logic [SLW-1:0]       r_scan_addr;
    logic [CW-1:0]        r_iss_cnt;
    logic                 r_rd_valid;
    logic                 r_rd_first;
    logic [SLW-1:0]       r_rd_slot;

    // divider lanes
    logic [DCW-1:0]       r_div_cnt;
    logic [PW-1:0]        r_rem_up;
    logic [NW-1:0]        r_q_up;
    logic [PW-1:0]        r_rem_dn;
    logic [NW-1:0]        r_q_dn;

    // output register
    logic                 r_out_valid;
    logic [OW-1:0]        r_aroon_up;
    logic [OW-1:0]        r_aroon_down;

    logic [CW-1:0]        win_size;
    logic [SLW-1:0]       next_slot;
    logic [SLW-1:0]       new_slot;
    logic                 was_full;
    logic [CW-1:0]        n_seen_count;
    logic                 full_now;
    logic                 force_scan;
    logic                 issue;
    logic signed [SW-1:0] hi_rd;
    logic signed [SW-1:0] lo_rd;
    logic [PW-1:0]        left_up;
    logic [PW-1:0]        left_dn;
    logic [NW-1:0]        num_up;
    logic [NW-1:0]        num_dn;
    logic [PW+NW-1:0]     step_up;
    logic [PW+NW-1:0]     step_dn;

    assign win_size  = CW'(i_period) + CW'(1);
    assign next_slot = ((CW'(r_newest_slot) + CW'(1)) == win_size) ? '0
                       : r_newest_slot + SLW'(1);
    assign new_slot  = (r_seen_count == '0) ? '0 : next_slot;
    assign was_full  = (r_seen_count >= win_size);
    assign n_seen_count = was_full ? r_seen_count : r_seen_count + CW'(1);
    assign full_now  = (n_seen_count >= win_size);
    assign force_scan = !was_full || !r_extremes_valid;
    assign issue     = i_cmd.scan_issue && (r_iss_cnt != win_size);

    awea_ram #(
        .WIDTH (SW),
        .DEPTH (awea_pkg::DEPTH)
    ) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (new_slot),
        .i_wdata (i_high_price),
        .i_re    (issue),
        .i_raddr (r_scan_addr),
        .o_rdata (hi_rd)
    );

    awea_ram #(
        .WIDTH (SW),
        .DEPTH (awea_pkg::DEPTH)
    ) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (new_slot),
        .i_wdata (i_low_price),
        .i_re    (issue),
        .i_raddr (r_scan_addr),
        .o_rdata (lo_rd)
    );

    assign left_up = i_period - PW'(age_of(r_newest_slot, r_highest_slot, win_size));
    assign left_dn = i_period - PW'(age_of(r_newest_slot, r_lowest_slot, win_size));
    assign num_up  = NW'(left_up) * NW'(awea_pkg::FULL_SCALE);
    assign num_dn  = NW'(left_dn) * NW'(awea_pkg::FULL_SCALE);
    assign step_up = div_iter(r_rem_up, r_q_up, i_period);
    assign step_dn = div_iter(r_rem_dn, r_q_dn, i_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_newest_slot    <= '0;
            r_seen_count     <= '0;
            r_highest_slot   <= '0;
            r_highest_value  <= '0;
            r_lowest_slot    <= '0;
            r_lowest_value   <= '0;
            r_extremes_valid <= 1'b0;
            r_emit           <= 1'b0;
            r_rescan_hi      <= 1'b0;
            r_rescan_lo      <= 1'b0;
            r_iss_cnt        <= '0;
            r_rd_valid       <= 1'b0;
            r_div_cnt        <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_newest_slot <= new_slot;
                r_seen_count  <= n_seen_count;
                r_emit        <= full_now;
                r_rescan_hi   <= full_now && (force_scan || (r_highest_slot == new_slot));
                r_rescan_lo   <= full_now && (force_scan || (r_lowest_slot == new_slot));
                if (full_now) begin
                    r_extremes_valid <= 1'b1;
                end
                // newer bar wins ties
                if (full_now && !force_scan && (r_highest_slot != new_slot)
                    && (i_high_price >= r_highest_value)) begin
                    r_highest_slot  <= new_slot;
                    r_highest_value <= i_high_price;
                end
                if (full_now && !force_scan && (r_lowest_slot != new_slot)
                    && (i_low_price <= r_lowest_value)) begin
                    r_lowest_slot  <= new_slot;
                    r_lowest_value <= i_low_price;
                end
            end

            // oldest entry first
            if (i_cmd.scan_start) begin
                r_scan_addr <= next_slot;
                r_iss_cnt   <= '0;
            end else if (issue) begin
                r_scan_addr <= ((CW'(r_scan_addr) + CW'(1)) == win_size) ? '0
                               : r_scan_addr + SLW'(1);
                r_iss_cnt   <= r_iss_cnt + CW'(1);
            end
            r_rd_valid <= issue;
            r_rd_first <= (r_iss_cnt == '0);
            r_rd_slot  <= r_scan_addr;

            if (r_rd_valid) begin
                if (r_rescan_hi && (r_rd_first || (hi_rd >= r_highest_value))) begin
                    r_highest_slot  <= r_rd_slot;
                    r_highest_value <= hi_rd;
                end
                if (r_rescan_lo && (r_rd_first || (lo_rd <= r_lowest_value))) begin
                    r_lowest_slot  <= r_rd_slot;
                    r_lowest_value <= lo_rd;
                end
            end

            if (i_cmd.div_start) begin
                r_div_cnt <= DCW'(NW);
            end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem_up <= '0;
            r_q_up   <= num_up;
            r_rem_dn <= '0;
            r_q_dn   <= num_dn;
        end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
            r_rem_up <= step_up[PW+NW-1:NW];
            r_q_up   <= step_up[NW-1:0];
            r_rem_dn <= step_dn[PW+NW-1:NW];
            r_q_dn   <= step_dn[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_aroon_up   <= r_q_up[OW-1:0];
            r_aroon_down <= r_q_dn[OW-1:0];
        end
    end

    assign o_status.emit      = r_emit;
    assign o_status.scan_need = r_rescan_hi || r_rescan_lo;
    assign o_status.scan_done = (r_iss_cnt == win_size) && !r_rd_valid;
    assign o_status.div_done  = (r_div_cnt == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_aroon_up   = r_aroon_up;
    assign o_aroon_down = r_aroon_down;

    `AWEA_ASSERT(a_seen_bounded, r_seen_count <= win_size, "fill count beyond window")
    `AWEA_ASSERT(a_newest_in_window, CW'(r_newest_slot) < win_size, "newest slot outside window")
    `AWEA_ASSERT_IMP(a_extremes_in_window, r_extremes_valid, (CW'(r_highest_slot) < win_size) && (CW'(r_lowest_slot) < win_size), "extreme slot outside window")
    `AWEA_ASSERT(a_issue_bounded, r_iss_cnt <= win_size, "rescan read past window")
    `AWEA_ASSERT_IMP(a_load_when_free, i_cmd.out_load, !r_out_valid || !i_out_stall, "output overwritten while held")

endmodule

@@ hw/rtl/aroon_window_extreme_age.sv @@
// aroon indicator block top level: register port, controller and datapath
// depends on awea_pkg, awea_ctrl, awea_dp
//
// input channel: i_in_valid / o_in_stall with i_high_price and i_low_price
// (signed), one bar per item. output channel: o_out_valid / i_out_stall with
// o_aroon_up and o_aroon_down, percent in 1/256 units (0 to 25600).
// register port: period at byte address 0, 1 to 255, zero reads back as one;
// a write clears the window and must happen while the block is idle.
// bars are stored until period+1 have been seen; from then on every bar
// yields one item. bars that yield nothing only pass the check state.
// an item passes the check, score, divide and emit states from accept to
// o_out_valid when the extremes are updated in place; when one has left the
// window, a scan state walks the period+1 stored bars (one read per cycle from
// the window stores); scores come from a 23-step shift-subtract divider by period.
// one bar is worked on at a time; the next is accepted as soon as the result
// sits in the output register, even while the receiver stalls it. a stalled
// result holds until taken, and the block waits before loading the next one.
// synchronous active-low reset: period returns to 14, the window is empty, no
// item is pending; no clearing pass is needed.
`timescale 1ns / 1ps

module aroon_window_extreme_age (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [awea_pkg::SAMPLE_WIDTH-1:0] i_high_price,
    input  logic signed [awea_pkg::SAMPLE_WIDTH-1:0] i_low_price,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic [awea_pkg::OUT_W-1:0]               o_aroon_up,
    output logic [awea_pkg::OUT_W-1:0]               o_aroon_down,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [awea_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [awea_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [awea_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    localparam int PW = awea_pkg::PERIOD_W;
    localparam int AW = awea_pkg::APB_ADDR_W;

    logic [PW-1:0]                       r_period;
    logic [PW-1:0]                       n_period;
    logic [awea_pkg::CFG_PERIOD_W-1:0]   wr_raw;
    logic [awea_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                cfg_wr;
    awea_pkg::t_cmd                      cmd;
    awea_pkg::t_status                   status;

    assign reg_idx = paddr[AW-1:2];
    assign wr_raw  = pwdata[awea_pkg::CFG_PERIOD_W-1:0];
    assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == awea_pkg::REG_PERIOD);
    assign pready  = 1'b1;

    always_comb begin
        priority if (wr_raw == '0) begin
            n_period = PW'(1);
        end else if (int'(wr_raw) > awea_pkg::MAX_PERIOD) begin
            n_period = PW'(awea_pkg::MAX_PERIOD);
        end else begin
            n_period = PW'(wr_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PW'(awea_pkg::PERIOD_RESET);
        end else if (cfg_wr) begin
            r_period <= n_period;
        end
    end

    assign prdata = (reg_idx == awea_pkg::REG_PERIOD) ? awea_pkg::APB_DATA_W'(r_period) : '0;

    awea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    awea_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_period     (r_period),
        .i_clear      (cfg_wr),
        .i_high_price (i_high_price),
        .i_low_price  (i_low_price),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_aroon_up   (o_aroon_up),
        .o_aroon_down (o_aroon_down)
    );

endmodule

@@ dv/aroon_window_extreme_age_checker.sv @@
// checker for the aroon window extreme age block: predicts aroon up/down per bar
// and compares every output item against the oldest prediction
// depends on awea_pkg
`timescale 1ns / 1ps

module aroon_window_extreme_age_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic [awea_pkg::SAMPLE_WIDTH-1:0]     i_high_price,
    input  logic [awea_pkg::SAMPLE_WIDTH-1:0]     i_low_price,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic [awea_pkg::OUT_W-1:0]            i_aroon_up,
    input  logic [awea_pkg::OUT_W-1:0]            i_aroon_down,
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [awea_pkg::APB_ADDR_W-1:0]       i_paddr,
    input  logic [awea_pkg::APB_DATA_W-1:0]       i_pwdata,
    input  logic                                  i_pready,
    output int                                    o_pending,
    output int                                    o_errors,
    output int                                    o_results
);
    import awea_pkg::*;

    localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [OUT_W-1:0] up;
        logic [OUT_W-1:0] down;
    } aroon_t;

    logic [SAMPLE_WIDTH-1:0] window_hi [DEPTH];
    logic [SAMPLE_WIDTH-1:0] window_lo [DEPTH];
    int unsigned             cur_period;
    int unsigned             newest;
    int unsigned             filled;
    int unsigned             top_slot;
    int unsigned             bot_slot;
    logic [SAMPLE_WIDTH-1:0] top_key;
    logic [SAMPLE_WIDTH-1:0] bot_key;
    bit                      ext_ok;
    aroon_t                  aroon_q [$];
    int                      errors = 0;
    int                      results = 0;

    function automatic void clear_window();
        newest   = 0;
        filled   = 0;
        top_slot = 0;
        top_key  = '0;
        bot_slot = 0;
        bot_key  = '0;
        ext_ok   = 1'b0;
    endfunction

    function automatic void set_period(input logic [APB_DATA_W-1:0] value);
        int unsigned p;
        p = value[CFG_PERIOD_W-1:0];
        if (p < 1) begin
            p = 1;
        end
        if (p > MAX_PERIOD) begin
            p = MAX_PERIOD;
        end
        cur_period = p;
        clear_window();
    endfunction

    // walk oldest to newest, newer bar wins ties
    function automatic void find_extreme(input int unsigned oldest, input int unsigned size,
                                         input bit want_high);
        int unsigned             k;
        int unsigned             s;
        int unsigned             best_slot;
        logic [SAMPLE_WIDTH-1:0] best;
        logic [SAMPLE_WIDTH-1:0] v;
        s = oldest;
        best_slot = s;
        best = want_high ? window_hi[s] : window_lo[s];
        for (k = 1; k < size; k++) begin
            s = (s + 1) % size;
            v = want_high ? window_hi[s] : window_lo[s];
            if (want_high ? (v >= best) : (v <= best)) begin
                best = v;
                best_slot = s;
            end
        end
        if (want_high) begin
            top_slot = best_slot;
            top_key  = best;
        end else begin
            bot_slot = best_slot;
            bot_key  = best;
        end
    endfunction

    function automatic logic [OUT_W-1:0] recency(input int unsigned slot, input int unsigned size);
        int unsigned age;
        int unsigned pct;
        age = (newest + size - slot) % size;
        pct = ((cur_period - age) * FULL_SCALE) / cur_period;
        return pct[OUT_W-1:0];
    endfunction

    function automatic void predict_bar(input logic [SAMPLE_WIDTH-1:0] hi_raw,
                                        input logic [SAMPLE_WIDTH-1:0] lo_raw);
        int unsigned             size;
        int unsigned             slot;
        int unsigned             oldest;
        logic [SAMPLE_WIDTH-1:0] hi;
        logic [SAMPLE_WIDTH-1:0] lo;
        bit                      was_full;
        size = cur_period + 1;
        // offset binary so unsigned compare follows signed order
        hi = hi_raw ^ SIGN_BIT;
        lo = lo_raw ^ SIGN_BIT;
        was_full = (filled >= size);
        slot = (filled == 0) ? 0 : (newest + 1) % size;
        window_hi[slot] = hi;
        window_lo[slot] = lo;
        newest = slot;
        if (filled < size) begin
            filled++;
        end
        if (filled < size) begin
            return;
        end
        oldest = (slot + 1) % size;
        if (!was_full || !ext_ok) begin
            find_extreme(oldest, size, 1'b1);
            find_extreme(oldest, size, 1'b0);
            ext_ok = 1'b1;
        end else begin
            if (top_slot == slot) begin
                find_extreme(oldest, size, 1'b1);
            end else if (hi >= top_key) begin
                top_slot = slot;
                top_key  = hi;
            end
            if (bot_slot == slot) begin
                find_extreme(oldest, size, 1'b0);
            end else if (lo <= bot_key) begin
                bot_slot = slot;
                bot_key  = lo;
            end
        end
        aroon_q.push_back('{up: recency(top_slot, size), down: recency(bot_slot, size)});
    endfunction

    always @(posedge i_clk) begin
        aroon_t want;
        if (!i_rst_n) begin
            cur_period = PERIOD_RESET;
            clear_window();
            aroon_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (aroon_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected item: expected none actual up %0d down %0d",
                             $time, i_aroon_up, i_aroon_down);
                end else begin
                    want = aroon_q.pop_front();
                    results++;
                    if (want.up !== i_aroon_up) begin
                        errors++;
                        $display("%0t aroon_up mismatch: expected %0d actual %0d",
                                 $time, want.up, i_aroon_up);
                    end
                    if (want.down !== i_aroon_down) begin
                        errors++;
                        $display("%0t aroon_down mismatch: expected %0d actual %0d",
                                 $time, want.down, i_aroon_down);
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[APB_ADDR_W-1:2] == REG_PERIOD) begin
                set_period(i_pwdata);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_bar(i_high_price, i_low_price);
            end
        end
        o_pending <= aroon_q.size();
        o_errors  <= errors;
        o_results <= results;
    end

endmodule

@@ dv/tb_aroon_window_extreme_age.sv @@
// testbench top for the aroon window extreme age block: clock, reset, bar and
// register stimulus with random idling, verdict from the checker's error count
// depends on awea_pkg, aroon_window_extreme_age, aroon_window_extreme_age_checker
`timescale 1ns / 1ps

module tb_aroon_window_extreme_age;
    import awea_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_PERIOD + 1'b1;
    localparam int     NUM_PHASES    = 9;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 8;
    localparam longint RUN_LIMIT_NS  = 64'd20_000_000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic signed [SAMPLE_WIDTH-1:0] i_high_price = '0;
    logic signed [SAMPLE_WIDTH-1:0] i_low_price = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [OUT_W-1:0]               o_aroon_up;
    logic [OUT_W-1:0]               o_aroon_down;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]          paddr = '0;
    logic [APB_DATA_W-1:0]          pwdata = '0;
    logic [APB_DATA_W-1:0]          prdata;
    logic                           pready;

    int pending;
    int errors;
    int results;

    int tx_idle_pct = 18;
    int rx_idle_pct = 72;
    int hold_ticket = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int bars = 0;
    int writes = 0;

    logic signed [SAMPLE_WIDTH-1:0] level = '0;
    int                             drift = 0;

    logic [SAMPLE_WIDTH-1:0] corners [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    logic [SAMPLE_WIDTH-1:0] dir_hi [20] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
        32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1,
        32'd1, 32'd1, 32'd1, 32'd1, 32'h8000_0000};
    logic [SAMPLE_WIDTH-1:0] dir_lo [20] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000,
        32'd2, 32'd2, 32'd2, 32'd2, 32'd2, 32'd2, 32'd2, 32'd2, 32'd2, 32'd2,
        32'd2, 32'd2, 32'd2, 32'd2, 32'h7FFF_FFFF};
    logic [SAMPLE_WIDTH-1:0] p1_hi [5] = '{32'd5, 32'd5, 32'd3, 32'd9, 32'd9};
    logic [SAMPLE_WIDTH-1:0] p1_lo [5] = '{32'd5, 32'd5, 32'd9, 32'd3, 32'd3};

    logic [APB_DATA_W-1:0] phase_value [NUM_PHASES] = '{
        32'h0, 32'd3, 32'hABCD_EF07, 32'd255, 32'd2, 32'd9, 32'd20, 32'd1, 32'd14};
    int phase_bars [NUM_PHASES] = '{12, 14, 14, 262, 14, 10, 30, 10, 18};

    aroon_window_extreme_age u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_high_price (i_high_price),
        .i_low_price  (i_low_price),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_aroon_up   (o_aroon_up),
        .o_aroon_down (o_aroon_down),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    aroon_window_extreme_age_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_high_price (i_high_price),
        .i_low_price  (i_low_price),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_aroon_up   (o_aroon_up),
        .i_aroon_down (o_aroon_down),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_errors     (errors),
        .o_results    (results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stall, or a long hold-off when a new ticket shows up
    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen   <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic push_bar(input logic [SAMPLE_WIDTH-1:0] hi, input logic [SAMPLE_WIDTH-1:0] lo);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_high_price <= hi;
        i_low_price  <= lo;
        do @(posedge i_clk); while (o_in_stall);
        bars++;
    endtask

    // stop offering bars and wait until every expected item has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        writes++;
    endtask

    // mostly a slow random walk so ties and expiring extremes are common
    task automatic make_bar(output logic [SAMPLE_WIDTH-1:0] hi,
                            output logic [SAMPLE_WIDTH-1:0] lo);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            hi = $urandom;
            lo = $urandom;
        end else if (r < 16) begin
            hi = corners[$urandom_range(0, 3)];
            lo = corners[$urandom_range(0, 3)];
        end else begin
            level = level + drift + int'($urandom_range(0, 4)) - 2;
            hi = level + int'($urandom_range(0, 1));
            lo = level - int'($urandom_range(0, 1));
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [SAMPLE_WIDTH-1:0] hi;
        logic [SAMPLE_WIDTH-1:0] lo;
        int                      p;
        int                      n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset period, newer-wins ties, extremes leaving the window
        for (n = 0; n < 20; n++) begin
            push_bar(dir_hi[n], dir_lo[n]);
        end
        drain();
        // period zero behaves as period one
        apb_write(REG_PERIOD, 32'h0);
        for (n = 0; n < 5; n++) begin
            push_bar(p1_hi[n], p1_lo[n]);
        end

        for (p = 0; p < NUM_PHASES; p++) begin
            drain();
            if (p < 3) begin
                tx_idle_pct = 18;
                rx_idle_pct <= 72;
            end else if (p < 6) begin
                tx_idle_pct = 72;
                rx_idle_pct <= 18;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            // the spare address must leave period and window untouched
            apb_write((p == 5) ? REG_SPARE : REG_PERIOD, phase_value[p]);
            level = $urandom;
            drift = (p % 2 == 0) ? -1 : 1;
            if (p == 4) begin
                hold_ticket <= hold_ticket + 1;
            end
            for (n = 0; n < phase_bars[p]; n++) begin
                if (p == 6 && n == phase_bars[p] / 2) begin
                    drain();
                end
                make_bar(hi, lo);
                push_bar(hi, lo);
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        $display("tb: %0d bars over %0d register writes, periods 1 to 255 with ties and expiries",
                 bars, writes);
        $display("tb: %0d aroon items compared, %0d mismatches", results, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
